// ----- hw/rtl/chlp_pkg.sv -----
`default_nettype none

package chlp_pkg;

  localparam int unsigned LebMaxBytes = 5;

  localparam logic [7:0] LebContBit = 8'h80;
  localparam logic [7:0] LebSignBit = 8'h40;
  localparam logic [7:0] LebDataMask = 8'h7F;

  localparam logic [31:0] CatchAllType = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] type_index;
    logic [31:0] handler_address;
    logic        is_catch_all;
    logic        handler_end;
    logic        list_end;
    logic [15:0] list_length;
    logic        malformed;
  } chlp_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/catch_handler_list_parser.sv -----
// A result item is registered in the output register, or in the skid slot behind a stalled item.
// Throughput: one byte per cycle while not stalled; the parser state updates in the accepting cycle.
// A two-entry output register with a skid slot keeps input flowing until a second result
// item waits behind a stalled one; input then stalls until the output takes an item.
// Reset: asynchronous, active low; the parser waits for the list count and the byte count is zero.
`default_nettype none

module catch_handler_list_parser
  import chlp_pkg::*;
#(
  parameter int unsigned MAX_LIST_BYTES = 65536
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  byte_in_i,
  input  wire logic        first_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      type_index_o,
  output logic [31:0]      handler_address_o,
  output logic             is_catch_all_o,
  output logic             handler_end_o,
  output logic             list_end_o,
  output logic [15:0]      list_length_o,
  output logic             malformed_o
);

  localparam logic [15:0] LenCap =
    (MAX_LIST_BYTES > 65535) ? 16'hFFFF : 16'(MAX_LIST_BYTES);

  typedef enum logic [2:0] {
    PhCount,
    PhSize,
    PhType,
    PhAddr,
    PhCatchAll,
    PhDone
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] acc_q, acc_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [31:0] handlers_q, handlers_d;
  logic [31:0] pairs_q, pairs_d;
  logic        ca_q, ca_d;
  logic [31:0] held_q, held_d;
  logic [15:0] seen_q, seen_d;

  chlp_res_t   out_q, skid_q, res;
  logic        out_valid_q, skid_valid_q;
  logic        res_valid;

  logic        accept, out_take;
  phase_e      ph;
  logic [31:0] acc_e, handlers_e, pairs_e, held_e, val, sval, ext_mask, addend;
  logic        ca_e, hend;
  logic [15:0] seen_base;
  logic [2:0]  cnt_e;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_take = out_valid_q && !out_stall_i;
  assign in_stall_o = skid_valid_q;

  always_comb begin
    ph         = first_i ? PhCount : phase_q;
    acc_e      = first_i ? '0 : acc_q;
    cnt_e      = first_i ? '0 : cnt_q;
    handlers_e = first_i ? '0 : handlers_q;
    pairs_e    = first_i ? '0 : pairs_q;
    ca_e       = first_i ? 1'b0 : ca_q;
    held_e     = first_i ? '0 : held_q;
    seen_base  = first_i ? '0 : seen_q;

    unique case (cnt_e)
      3'd0: begin
        addend   = {25'b0, byte_in_i[6:0]};
        ext_mask = 32'hFFFF_FF80;
      end
      3'd1: begin
        addend   = {18'b0, byte_in_i[6:0], 7'b0};
        ext_mask = 32'hFFFF_C000;
      end
      3'd2: begin
        addend   = {11'b0, byte_in_i[6:0], 14'b0};
        ext_mask = 32'hFFE0_0000;
      end
      3'd3: begin
        addend   = {4'b0, byte_in_i[6:0], 21'b0};
        ext_mask = 32'hF000_0000;
      end
      3'd4: begin
        addend   = {byte_in_i[3:0], 28'b0};
        ext_mask = '0;
      end
      default: begin
        addend   = '0;
        ext_mask = '0;
      end
    endcase

    val  = acc_e | addend;
    sval = ((byte_in_i & LebSignBit) != 8'h00) ? (val | ext_mask) : val;
    hend = 1'b0;

    seen_d = (seen_base < LenCap) ? seen_base + 16'd1 : seen_base;

    phase_d    = ph;
    acc_d      = acc_e;
    cnt_d      = cnt_e;
    handlers_d = handlers_e;
    pairs_d    = pairs_e;
    ca_d       = ca_e;
    held_d     = held_e;

    res_valid           = 1'b0;
    res.type_index      = '0;
    res.handler_address = val;
    res.is_catch_all    = 1'b0;
    res.handler_end     = 1'b0;
    res.list_end        = 1'b0;
    res.list_length     = seen_d;
    res.malformed       = 1'b0;

    if (ph != PhDone) begin
      if ((byte_in_i & LebContBit) != 8'h00) begin
        if (32'(cnt_e) + 32'd1 >= LebMaxBytes) begin
          phase_d    = PhDone;
          acc_d      = '0;
          cnt_d      = '0;
          handlers_d = '0;
          pairs_d    = '0;
          ca_d       = 1'b0;
          held_d     = '0;
          res_valid           = 1'b1;
          res.handler_address = '0;
          res.list_end        = 1'b1;
          res.malformed       = 1'b1;
        end else begin
          acc_d = val;
          cnt_d = cnt_e + 3'd1;
        end
      end else begin
        acc_d = '0;
        cnt_d = '0;
        unique case (ph)
          PhCount: begin
            handlers_d = val;
            phase_d    = (val == '0) ? PhDone : PhSize;
          end
          PhSize: begin
            if (sval != '0 && !sval[31]) begin
              pairs_d = sval;
              ca_d    = 1'b0;
            end else begin
              pairs_d = '0 - sval;
              ca_d    = 1'b1;
            end
            phase_d = (pairs_d != '0) ? PhType : PhCatchAll;
          end
          PhType: begin
            held_d  = val;
            pairs_d = pairs_e - 32'd1;
            phase_d = PhAddr;
          end
          PhAddr: begin
            hend = (pairs_e == '0) && !ca_e;
            if (hend) begin
              handlers_d = handlers_e - 32'd1;
              phase_d    = (handlers_d == '0) ? PhDone : PhSize;
            end else begin
              phase_d = (pairs_e != '0) ? PhType : PhCatchAll;
            end
            res_valid       = 1'b1;
            res.type_index  = held_e;
            res.handler_end = hend;
            res.list_end    = hend && (phase_d == PhDone);
          end
          PhCatchAll: begin
            ca_d       = 1'b0;
            handlers_d = handlers_e - 32'd1;
            phase_d    = (handlers_d == '0) ? PhDone : PhSize;
            res_valid        = 1'b1;
            res.type_index   = CatchAllType;
            res.is_catch_all = 1'b1;
            res.handler_end  = 1'b1;
            res.list_end     = (phase_d == PhDone);
          end
          default: begin
            phase_d = PhDone;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhCount;
      acc_q        <= '0;
      cnt_q        <= '0;
      handlers_q   <= '0;
      pairs_q      <= '0;
      ca_q         <= 1'b0;
      held_q       <= '0;
      seen_q       <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q    <= phase_d;
        acc_q      <= acc_d;
        cnt_q      <= cnt_d;
        handlers_q <= handlers_d;
        pairs_q    <= pairs_d;
        ca_q       <= ca_d;
        held_q     <= held_d;
        seen_q     <= seen_d;
      end
      if (skid_valid_q) begin
        if (out_take) begin
          skid_valid_q <= 1'b0;
        end
      end else if (accept && res_valid) begin
        if (out_valid_q && !out_take) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (accept && res_valid) begin
      if (out_valid_q && !out_take) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign type_index_o      = out_q.type_index;
  assign handler_address_o = out_q.handler_address;
  assign is_catch_all_o    = out_q.is_catch_all;
  assign handler_end_o     = out_q.handler_end;
  assign list_end_o        = out_q.list_end;
  assign list_length_o     = out_q.list_length;
  assign malformed_o       = out_q.malformed;

endmodule

`default_nettype wire
